// ----- rtl/mbrtu_pkg.sv -----
// Shared types, codes and the CRC-16/Modbus byte update for the Modbus RTU frame engine.
// No dependencies.
package mbrtu_pkg;

  localparam int unsigned FrameBytes    = 8;
  localparam int unsigned RegisterCount = 128;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0]  FuncRead  = 8'd3;
  localparam logic [7:0]  FuncWrite = 8'd6;

  localparam logic [15:0] CmdOperate = 16'h0001;
  localparam logic [15:0] CmdStop    = 16'h0002;
  localparam logic [15:0] CmdPreOp   = 16'h0080;

  // only this register feeds any logic (motor duty on an operate command)
  localparam logic [15:0] DutyRegIndex  = 16'd6;
  localparam logic [15:0] MotorRegIndex = 16'd0;

  typedef enum logic [1:0] {
    StatusAnswered     = 2'd0,
    StatusCrcError     = 2'd1,
    StatusAddrMismatch = 2'd2,
    StatusNotHandled   = 2'd3
  } frame_status_e;

  typedef logic [7:0] byte_t;

  // reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input byte_t b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/modbus_rtu_slave_frame_engine_top.sv -----
// Modbus RTU slave frame engine: collects 8-byte frames, checks CRC and address,
// handles read (3) and write (6) functions and drives motor pins and PWM duty.
// Depends on mbrtu_pkg.
//
// Usage:
//   s_axis carries one received byte per transfer together with the current
//   converter sample. Bytes 0..6 of a frame give no result. The eighth byte
//   completes the frame: an answered frame yields eight reply bytes on m_axis
//   (tuser tx_valid high, tlast on the eighth); any other outcome yields one
//   status-only transfer with tlast high.
//   Latency: the first result is presented the cycle after the eighth byte.
//   Throughput: one input byte per cycle; one result per cycle. The eighth
//   byte of a frame is held off only while the previous frame's replies are
//   still queued in the 8-byte reply buffer, so a ready receiver sustains one
//   byte per cycle. The CRC is updated one byte per cycle by an unrolled step.
//   When the receiver stalls, the current result holds and bytes 0..6 of the
//   next frame are still taken. Reset clears the byte position, CRC, last
//   command, motor pins, duty, LED flag and register 6, and sets the node
//   address to 1. No clearing sweep is needed. cfg_we_i writes the node
//   address; the user must do so only while idle, as the block does not check.
module modbus_rtu_slave_frame_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // server_address
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // [7:0] rx_byte, [17:8] adc_sample, [23:18] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // [7:0] tx_byte, [8] motor_a, [9] motor_b,
                                       // [17:10] pwm_duty, [18] led_off, [23:19] zero
  output logic [2:0]  m_axis_tuser,    // [0] tx_valid, [2:1] frame_status
  output logic        m_axis_tlast
);
  import mbrtu_pkg::*;

  localparam int unsigned PosW = $clog2(FrameBytes);
  localparam logic [PosW-1:0] LastPos = PosW'(FrameBytes - 1);

  logic [7:0]     addr_q, addr_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]    crc_q, crc_d;
  logic [15:0]    crc4_q, crc4_d;
  byte_t          frame_q [FrameBytes-1];
  byte_t          frame_d [FrameBytes-1];
  logic [7:0]     last_cmd_q, last_cmd_d;
  logic [15:0]    reg6_q, reg6_d;
  logic           motor_a_q, motor_a_d;
  logic           motor_b_q, motor_b_d;
  logic [7:0]     duty_q, duty_d;
  logic           led_off_q, led_off_d;

  byte_t          reply_q [FrameBytes];
  byte_t          reply_d [FrameBytes];
  logic           busy_q, busy_d;
  logic           single_q, single_d;
  frame_status_e  status_q, status_d;
  logic [PosW-1:0] ptr_q, ptr_d;

  logic        s_xfer, m_xfer, frame_done, out_last;
  byte_t       rx_byte;
  logic [9:0]  sample;
  logic [15:0] rx_crc, regis, data, reply_crc;
  byte_t       sample_hi;
  logic [15:0] crc_next;

  assign rx_byte   = s_axis_tdata[7:0];
  assign sample    = s_axis_tdata[17:8];
  assign sample_hi = {6'b0, sample[9:8]};

  assign out_last      = single_q || (ptr_q == LastPos);
  assign m_axis_tvalid = busy_q;
  assign m_xfer        = m_axis_tvalid && m_axis_tready;
  // the completing byte needs the reply buffer free or draining now
  assign s_axis_tready = (pos_q != LastPos) || !busy_q || (m_xfer && out_last);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign frame_done    = s_xfer && (pos_q == LastPos);

  assign rx_crc    = {frame_q[6], rx_byte};
  assign regis     = {frame_q[2], frame_q[3]};
  assign data      = {frame_q[4], frame_q[5]};
  assign crc_next  = crc_byte(crc_q, rx_byte);
  // header bytes 0..3 of a read reply match the request, so resume from crc4
  assign reply_crc = crc_byte(crc_byte(crc4_q, sample_hi), sample[7:0]);

  always_comb begin
    addr_d     = addr_q;
    pos_d      = pos_q;
    crc_d      = crc_q;
    crc4_d     = crc4_q;
    frame_d    = frame_q;
    last_cmd_d = last_cmd_q;
    reg6_d     = reg6_q;
    motor_a_d  = motor_a_q;
    motor_b_d  = motor_b_q;
    duty_d     = duty_q;
    led_off_d  = led_off_q;
    reply_d    = reply_q;
    busy_d     = busy_q;
    single_d   = single_q;
    status_d   = status_q;
    ptr_d      = ptr_q;

    if (cfg_we_i) begin
      addr_d = cfg_wdata_i;
    end

    // drain the reply buffer
    if (m_xfer) begin
      if (out_last) begin
        busy_d = 1'b0;
      end else begin
        ptr_d = ptr_q + 1'b1;
      end
    end

    if (s_xfer && !frame_done) begin
      frame_d[pos_q] = rx_byte;
      pos_d          = pos_q + 1'b1;
      if (pos_q < PosW'(6)) begin
        crc_d = crc_next;
      end
      if (pos_q == PosW'(3)) begin
        crc4_d = crc_next;
      end
    end

    if (frame_done) begin
      pos_d  = '0;
      crc_d  = CrcInit;
      busy_d = 1'b1;
      ptr_d  = '0;
      for (int i = 0; i < FrameBytes - 1; i++) begin
        reply_d[i] = frame_q[i];
      end
      reply_d[FrameBytes-1] = rx_byte;

      if (rx_crc != crc_q) begin
        single_d = 1'b1;
        status_d = StatusCrcError;
      end else if (frame_q[0] != addr_q) begin
        led_off_d = 1'b1;
        single_d  = 1'b1;
        status_d  = StatusAddrMismatch;
      end else if (frame_q[1] == FuncRead) begin
        single_d   = 1'b0;
        status_d   = StatusAnswered;
        last_cmd_d = data[7:0];
        if (regis == DutyRegIndex) begin
          reg6_d = {6'b0, sample};
        end
        reply_d[4] = sample_hi;
        reply_d[5] = sample[7:0];
        reply_d[6] = reply_crc[15:8];
        reply_d[7] = reply_crc[7:0];
      end else if (frame_q[1] == FuncWrite) begin
        single_d   = 1'b0;
        status_d   = StatusAnswered;
        last_cmd_d = data[7:0];
        if (regis == MotorRegIndex) begin
          if (data == CmdPreOp) begin
            if (last_cmd_q != CmdPreOp[7:0]) begin
              motor_a_d = 1'b0;
              motor_b_d = 1'b1;
            end
          end else if (data == CmdOperate) begin
            if (last_cmd_q != CmdOperate[7:0]) begin
              motor_a_d = 1'b0;
              motor_b_d = 1'b1;
              // register 6 / 4, saturated at 255
              duty_d = (reg6_q[15:10] != '0) ? 8'hFF : reg6_q[9:2];
            end
          end else if (data == CmdStop) begin
            if (last_cmd_q != CmdStop[7:0]) begin
              motor_a_d = 1'b0;
              motor_b_d = 1'b0;
            end
          end
        end else if (regis == DutyRegIndex) begin
          reg6_d = data;
        end
      end else begin
        single_d = 1'b1;
        status_d = StatusNotHandled;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= 8'd1;
      pos_q      <= '0;
      crc_q      <= CrcInit;
      last_cmd_q <= '0;
      reg6_q     <= '0;
      motor_a_q  <= 1'b0;
      motor_b_q  <= 1'b0;
      duty_q     <= '0;
      led_off_q  <= 1'b0;
      busy_q     <= 1'b0;
      single_q   <= 1'b0;
      status_q   <= StatusAnswered;
      ptr_q      <= '0;
    end else begin
      addr_q     <= addr_d;
      pos_q      <= pos_d;
      crc_q      <= crc_d;
      last_cmd_q <= last_cmd_d;
      reg6_q     <= reg6_d;
      motor_a_q  <= motor_a_d;
      motor_b_q  <= motor_b_d;
      duty_q     <= duty_d;
      led_off_q  <= led_off_d;
      busy_q     <= busy_d;
      single_q   <= single_d;
      status_q   <= status_d;
      ptr_q      <= ptr_d;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    crc4_q  <= crc4_d;
    frame_q <= frame_d;
    reply_q <= reply_d;
  end

  assign m_axis_tdata = {5'b0, led_off_q, duty_q, motor_b_q, motor_a_q,
                         single_q ? 8'h00 : reply_q[ptr_q]};
  assign m_axis_tuser = {status_q, !single_q};
  assign m_axis_tlast = out_last;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for modbus_rtu_slave_frame_engine_top: drives frame bytes on the
// input stream and checks every reply or status transfer against a local frame predictor.
// Depends on mbrtu_pkg and the engine RTL.
module testbench;
  import mbrtu_pkg::*;

  typedef struct packed {
    byte_t         tx;
    logic          vld;
    logic          lst;
    frame_status_e status;
    logic          ma;
    logic          mb;
    logic [7:0]    duty;
    logic          led;
  } reply_t;

  typedef enum int {
    GoodFrame,
    ForeignAddr,
    OddFunction,
    CorruptFrame,
    TruncatedFrame
  } traffic_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // predictor state
  byte_t       node_addr;
  logic [2:0]  m_pos;
  byte_t       frame_buf [8];
  logic [15:0] m_crc;
  byte_t       m_last_cmd;
  logic [15:0] m_regs [RegisterCount];
  logic [1:0]  m_pins;
  logic [7:0]  m_duty;
  logic        m_led;

  reply_t pending_replies[$];
  int     err_cnt;
  bit     src_gaps;
  bit     sink_stalls;
  int     hold_len;

  modbus_rtu_slave_frame_engine_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input byte_t b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void log_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void queue_reply(input byte_t tx, input logic vld, input logic lst,
                                      input frame_status_e status);
    pending_replies.push_back('{tx: tx, vld: vld, lst: lst, status: status, ma: m_pins[0],
                                mb: m_pins[1], duty: m_duty, led: m_led});
  endfunction

  // a command acts only when the previous command byte differs from it
  function automatic void run_motor_command(input logic [15:0] cmd);
    logic [15:0] d;
    if (cmd == CmdPreOp) begin
      if (m_last_cmd != CmdPreOp[7:0]) m_pins = 2'b10;
    end else if (cmd == CmdOperate) begin
      if (m_last_cmd != CmdOperate[7:0]) begin
        d = m_regs[DutyRegIndex[6:0]] >> 2;
        m_pins = 2'b10;
        m_duty = (d > 16'd255) ? 8'hFF : d[7:0];
      end
    end else if (cmd == CmdStop) begin
      if (m_last_cmd != CmdStop[7:0]) m_pins = 2'b00;
    end
  endfunction

  function automatic void absorb_rx_byte(input byte_t b, input logic [9:0] adc);
    logic [15:0] idx;
    logic [15:0] data;
    logic [15:0] c;
    byte_t       reply [8];
    frame_buf[m_pos] = b;
    if (m_pos < 3'd6) m_crc = crc16_update(m_crc, b);
    if (m_pos != 3'd7) begin
      m_pos++;
      return;
    end
    m_pos = 3'd0;
    c     = m_crc;
    m_crc = CrcInit;
    idx   = {frame_buf[2], frame_buf[3]};
    data  = {frame_buf[4], frame_buf[5]};
    if ({frame_buf[6], frame_buf[7]} != c) begin
      queue_reply(8'h00, 1'b0, 1'b1, StatusCrcError);
      return;
    end
    if (frame_buf[0] != node_addr) begin
      m_led = 1'b1;
      queue_reply(8'h00, 1'b0, 1'b1, StatusAddrMismatch);
      return;
    end
    if (frame_buf[1] == FuncRead) begin
      for (int i = 0; i < 4; i++) reply[i] = frame_buf[i];
      reply[4]   = {6'd0, adc[9:8]};
      reply[5]   = adc[7:0];
      m_last_cmd = data[7:0];
      if (idx < RegisterCount) m_regs[idx[6:0]] = {6'd0, adc};
      c = CrcInit;
      for (int i = 0; i < 6; i++) c = crc16_update(c, reply[i]);
      reply[6] = c[15:8];
      reply[7] = c[7:0];
    end else if (frame_buf[1] == FuncWrite) begin
      if (idx == MotorRegIndex) begin
        run_motor_command(data);
      end else if (idx < RegisterCount) begin
        m_regs[idx[6:0]] = data;
      end
      m_last_cmd = data[7:0];
      for (int i = 0; i < 8; i++) reply[i] = frame_buf[i];
    end else begin
      queue_reply(8'h00, 1'b0, 1'b1, StatusNotHandled);
      return;
    end
    for (int i = 0; i < 8; i++) queue_reply(reply[i], 1'b1, i == 7, StatusAnswered);
  endfunction

  function automatic logic [63:0] build_frame(input byte_t addr, input byte_t func,
                                              input logic [15:0] idx, input logic [15:0] data);
    logic [63:0] f;
    logic [15:0] c;
    f = '0;
    f[47:0] = {data[7:0], data[15:8], idx[7:0], idx[15:8], func, addr};
    c = CrcInit;
    for (int i = 0; i < 6; i++) c = crc16_update(c, f[8*i +: 8]);
    // high byte of the CRC goes out first
    f[63:48] = {c[7:0], c[15:8]};
    return f;
  endfunction

  // one transfer per call; tvalid stays high afterwards until the next call or a drain
  task automatic push_byte(input byte_t b, input logic [9:0] adc);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, adc, b};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    absorb_rx_byte(b, adc);
  endtask

  task automatic send_frame(input logic [63:0] f, input logic [9:0] adc);
    for (int i = 0; i < 8; i++) push_byte(f[8*i +: 8], adc);
  endtask

  // pad a broken frame up to its eighth byte
  task automatic realign_frame();
    while (m_pos != 3'd0) push_byte(8'($urandom), 10'($urandom));
  endtask

  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_node_address(input byte_t a);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    node_addr = a;
  endtask

  task automatic test_read_and_write();
    send_frame(build_frame(node_addr, FuncRead, 16'd5, 16'h00FF), 10'h3FF);
    send_frame(build_frame(node_addr, FuncRead, 16'd128, 16'hFFFF), 10'h000);
    send_frame(build_frame(node_addr, FuncWrite, DutyRegIndex, 16'hFFFF), 10'h155);
    send_frame(build_frame(node_addr, FuncWrite, 16'd128, 16'h1234), 10'h0F0);
    drain_replies();
  endtask

  task automatic test_motor_commands();
    send_frame(build_frame(node_addr, FuncWrite, MotorRegIndex, CmdPreOp), 10'd1);
    // register 6 holds 0xFFFF here, so the duty saturates
    send_frame(build_frame(node_addr, FuncWrite, MotorRegIndex, CmdOperate), 10'd2);
    send_frame(build_frame(node_addr, FuncWrite, MotorRegIndex, CmdStop), 10'd3);
    // low byte matches operate, so the next operate is ignored
    send_frame(build_frame(node_addr, FuncWrite, MotorRegIndex, 16'h0101), 10'd4);
    send_frame(build_frame(node_addr, FuncWrite, MotorRegIndex, CmdOperate), 10'd5);
    drain_replies();
  endtask

  task automatic test_frame_errors();
    logic [63:0] f;
    f = build_frame(node_addr, FuncRead, 16'd1, 16'd0);
    f[55:48] = f[55:48] ^ 8'h01;
    send_frame(f, 10'd0);
    send_frame(build_frame(node_addr, 8'h10, 16'd1, 16'd1), 10'd0);
    send_frame(build_frame(node_addr ^ 8'hFF, FuncRead, 16'd1, 16'd1), 10'd0);
    drain_replies();
  endtask

  task automatic test_node_address();
    set_node_address(8'h00);
    send_frame(build_frame(8'h00, FuncRead, 16'd9, 16'h5A5A), 10'h1FF);
    send_frame(build_frame(8'h01, FuncRead, 16'd9, 16'h5A5A), 10'h1FF);
    drain_replies();
  endtask

  // stall the receiver long enough that the reply buffer fills and the input stalls
  task automatic test_backpressure();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    hold_len    = 300;
    // wait until the receiver has started holding off
    while (hold_len != 0) @(posedge clk_i);
    for (int n = 0; n < 2; n++) begin
      send_frame(build_frame(node_addr, FuncRead, 16'(n), 16'($urandom)), 10'($urandom));
    end
    drain_replies();
  endtask

  task automatic test_random_traffic(input int frames);
    traffic_e    kind;
    logic [63:0] f;
    logic [15:0] idx;
    logic [15:0] data;
    byte_t       func;
    int          pick;
    for (int n = 0; n < frames; n++) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 6) ? GoodFrame : (pick == 6) ? ForeignAddr : (pick == 7) ? OddFunction :
             (pick == 8) ? CorruptFrame : TruncatedFrame;
      idx  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9));
      data = 16'($urandom);
      func = $urandom_range(0, 1) ? FuncRead : FuncWrite;
      if (idx == MotorRegIndex && $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 2))
          0:       data = CmdPreOp;
          1:       data = CmdOperate;
          default: data = CmdStop;
        endcase
      end
      realign_frame();
      f = build_frame(node_addr, func, idx, data);
      case (kind)
        GoodFrame: begin
          send_frame(f, 10'($urandom));
        end
        ForeignAddr: begin
          send_frame(build_frame(node_addr + 8'($urandom_range(1, 255)), func, idx, data),
                     10'($urandom));
        end
        OddFunction: begin
          func = 8'($urandom);
          if (func == FuncRead || func == FuncWrite) func = func ^ 8'h80;
          send_frame(build_frame(node_addr, func, idx, data), 10'($urandom));
        end
        CorruptFrame: begin
          f = f ^ (64'($urandom_range(1, 255)) << (8 * $urandom_range(0, 7)));
          send_frame(f, 10'($urandom));
        end
        default: begin
          repeat ($urandom_range(1, 7)) push_byte(8'($urandom), 10'($urandom));
        end
      endcase
      // pause the sender until every pending reply is back
      if (n == frames / 2) drain_replies();
    end
    realign_frame();
    drain_replies();
  endtask

  always @(posedge clk_i) begin : reply_check
    reply_t got;
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tlast, m_axis_tuser[2:1],
             m_axis_tdata[8], m_axis_tdata[9], m_axis_tdata[17:10], m_axis_tdata[18]};
      if (pending_replies.size() == 0) begin
        log_error($sformatf("unexpected transfer tx=%h tuser=%b", got.tx, m_axis_tuser));
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          log_error($sformatf({"reply mismatch want tx=%h vld=%b last=%b st=%0d a=%b b=%b ",
                               "duty=%0d led=%b got tx=%h vld=%b last=%b st=%0d a=%b b=%b ",
                               "duty=%0d led=%b"},
                              want.tx, want.vld, want.lst, want.status, want.ma, want.mb,
                              want.duty, want.led, got.tx, got.vld, got.lst, got.status,
                              got.ma, got.mb, got.duty, got.led));
        end
      end
    end
  end

  initial begin : sink_ready
    int n;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        m_axis_tready <= 1'b0;
        n        = hold_len;
        hold_len = 0;
        repeat (n - 1) @(posedge clk_i);
      end else if (sink_stalls && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_stalls) repeat ($urandom_range(1, 19) - 1) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    #6_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : run
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 8'h00;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    err_cnt     = 0;
    hold_len    = 0;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    node_addr   = 8'd1;
    m_pos       = 3'd0;
    m_crc       = CrcInit;
    m_last_cmd  = 8'h00;
    m_pins      = 2'b00;
    m_duty      = 8'h00;
    m_led       = 1'b0;
    for (int i = 0; i < RegisterCount; i++) m_regs[i] = 16'h0000;
    for (int i = 0; i < 8; i++) frame_buf[i] = 8'h00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_read_and_write();
    test_motor_commands();
    test_frame_errors();
    test_node_address();
    test_backpressure();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    test_random_traffic(2);
    set_node_address(8'($urandom));
    test_random_traffic(2);
    set_node_address(8'd1);
    // no idling in the closing stretch
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    test_random_traffic(2);
    repeat (8) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
